// ===== rtl/pwmcd_pkg.sv =====
// shared types and constants of the two-channel pwm with clock divider
package pwmcd_pkg;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register blocks
    localparam logic REGION_PWM = 1'b0;
    localparam logic REGION_CLK = 1'b1;

    // register word offsets
    localparam logic [5:0] OFF_CTL    = 6'd0;
    localparam logic [5:0] OFF_CLKCTL = 6'd40;
    localparam logic [5:0] OFF_CLKDIV = 6'd41;

    // register select inside a channel's group of four words
    localparam logic [1:0] SEL_RANGE = 2'd0;
    localparam logic [1:0] SEL_DATA  = 2'd1;

    // clock manager fields
    localparam logic [7:0] CLK_PASSWORD = 8'h5A;
    localparam int         CLK_EN_BIT   = 4;
    localparam int         CLK_BUSY_BIT = 7;
    localparam int         CLK_CTL_W    = 5;
    localparam int         DIV_LSB      = 12;

    // reset value of a channel range register
    localparam logic [31:0] RANGE_RESET = 32'd32;

    // input transfer payload
    typedef struct packed {
        logic [1:0]  operation;
        logic        region;
        logic [5:0]  word_offset;
        logic [31:0] write_data;
    } pwmcd_in_t;

    // result transfer payload
    typedef struct packed {
        logic [31:0] read_data;
        logic        pwm_level_0;
        logic        pwm_level_1;
    } pwmcd_out_t;

    // per channel command
    typedef struct packed {
        logic wr_range;
        logic wr_data;
        logic expire;
        logic enable;
    } pwmcd_chan_cmd_t;

    // clock manager command
    typedef struct packed {
        logic tick;
        logic wr_ctl;
        logic wr_div;
    } pwmcd_clk_cmd_t;

    // clock manager status
    typedef struct packed {
        logic expire;
        logic enable;
        logic busy;
    } pwmcd_clk_stat_t;

endpackage

// ===== rtl/pwmcd_clk.sv =====
// clock manager: control, divider, prescaler and busy flag
module pwmcd_clk
    import pwmcd_pkg::*;
#(
    parameter int DIVIDER_BITS = 12
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  pwmcd_clk_cmd_t  cmd,
    input  logic [31:0]     wdata,
    output pwmcd_clk_stat_t stat,
    output logic [31:0]     rd_ctl,
    output logic [31:0]     rd_div
);

    logic [CLK_CTL_W-1:0]    ctl_reg, ctl_next;
    logic [DIVIDER_BITS-1:0] div_reg, div_next;
    logic [DIVIDER_BITS-1:0] presc_reg, presc_next;
    logic                    busy_reg, busy_next;
    logic [DIVIDER_BITS:0]   presc_inc;
    logic [DIVIDER_BITS:0]   div_eff;
    logic                    enable;
    logic                    expire;

    assign enable    = ctl_reg[CLK_EN_BIT];
    assign presc_inc = {1'b0, presc_reg} + {{DIVIDER_BITS{1'b0}}, 1'b1};
    assign div_eff   = (div_reg == '0) ? {{DIVIDER_BITS{1'b0}}, 1'b1} : {1'b0, div_reg};
    assign expire    = cmd.tick && enable && !(presc_inc < div_eff);

    // next state of the clock manager
    always_comb begin
        ctl_next   = ctl_reg;
        div_next   = div_reg;
        presc_next = presc_reg;
        busy_next  = busy_reg;
        if (cmd.wr_ctl) begin
            ctl_next = wdata[CLK_CTL_W-1:0];
            if (wdata[CLK_EN_BIT]) begin
                busy_next = 1'b1;
            end
        end
        if (cmd.wr_div) begin
            div_next = wdata[DIV_LSB +: DIVIDER_BITS];
        end
        if (cmd.tick) begin
            if (!enable) begin
                busy_next = 1'b0;
            end else if (expire) begin
                presc_next = '0;
            end else begin
                presc_next = presc_inc[DIVIDER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg   <= '0;
            div_reg   <= '0;
            presc_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            ctl_reg   <= ctl_next;
            div_reg   <= div_next;
            presc_reg <= presc_next;
            busy_reg  <= busy_next;
        end
    end

    // register read values
    always_comb begin
        rd_ctl = 32'(ctl_reg);
        rd_ctl[CLK_BUSY_BIT] = busy_reg;
        rd_div = 32'(div_reg) << DIV_LSB;
    end

    assign stat.expire = expire;
    assign stat.enable = enable;
    assign stat.busy   = busy_reg;

endmodule

// ===== rtl/pwmcd_chan.sv =====
// one pwm channel: range, data, counter and output level
module pwmcd_chan
    import pwmcd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  pwmcd_chan_cmd_t cmd,
    input  logic [31:0]     wdata,
    output logic [31:0]     rd_range,
    output logic [31:0]     rd_data,
    output logic            level_next
);

    logic [31:0] range_reg, range_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [32:0] cnt_inc;

    assign cnt_inc = {1'b0, cnt_reg} + 33'd1;

    // register writes and counter advance
    always_comb begin
        range_next = cmd.wr_range ? wdata : range_reg;
        data_next  = cmd.wr_data ? wdata : data_reg;
        cnt_next   = cnt_reg;
        if (cmd.expire && cmd.enable) begin
            cnt_next = (cnt_inc >= {1'b0, range_reg}) ? 32'd0 : cnt_inc[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
            data_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            range_reg <= range_next;
            data_reg  <= data_next;
            cnt_reg   <= cnt_next;
        end
    end

    // level as it stands after this transfer
    assign level_next = cmd.enable && (cnt_next < data_next);

    assign rd_range = range_reg;
    assign rd_data  = data_reg;

endmodule

// ===== rtl/two_channel_pwm_with_clock_divider.sv =====
// two-channel mark-space pwm with clock manager: top level
// flow: an accepted transfer is held in the input register, and its result is written to
// the output register once the output stage is free (m_valid low or m_ready high)
// throughput: one transfer per cycle unless m_ready stalls; all register and counter
// work for an item is one pass between the input register and the output register
// reset: synchronous active low on aresetn; both stages empty, registers at reset values
module two_channel_pwm_with_clock_divider
    import pwmcd_pkg::*;
#(
    parameter int CHANNELS     = 2,
    parameter int DIVIDER_BITS = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pwmcd_in_t  s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output pwmcd_out_t m_item
);

    localparam int CTL_W = 8 * CHANNELS;

    logic            in_valid_reg;
    pwmcd_in_t       in_reg;
    logic            m_valid_reg;
    pwmcd_out_t      m_item_reg, m_item_next;
    logic            advance;

    logic [CTL_W-1:0] ctl_reg, ctl_next;

    logic            is_read, is_write, is_tick;
    logic            wr_pwm, wr_clk;
    pwmcd_clk_cmd_t  clk_cmd;
    pwmcd_clk_stat_t clk_stat;
    logic [31:0]     clk_rd_ctl, clk_rd_div;

    pwmcd_chan_cmd_t chan_cmd [CHANNELS];
    logic [31:0]     chan_rd_range [CHANNELS];
    logic [31:0]     chan_rd_data [CHANNELS];
    logic            chan_level [CHANNELS];
    logic [31:0]     chan_rd [CHANNELS];
    logic            level1;
    logic [31:0]     rd_value;

    // input stage and output stage handshakes
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_item;
        end
    end

    // item decode
    assign is_read  = advance && (in_reg.operation == OP_READ);
    assign is_write = advance && (in_reg.operation == OP_WRITE);
    assign is_tick  = advance && (in_reg.operation == OP_TICK);
    assign wr_pwm   = is_write && (in_reg.region == REGION_PWM);
    assign wr_clk   = is_write && (in_reg.region == REGION_CLK)
                      && (in_reg.write_data[31:24] == CLK_PASSWORD);

    // channel control register
    assign ctl_next = (wr_pwm && in_reg.word_offset == OFF_CTL)
                      ? in_reg.write_data[CTL_W-1:0] : ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    // clock manager
    assign clk_cmd.tick   = is_tick;
    assign clk_cmd.wr_ctl = wr_clk && (in_reg.word_offset == OFF_CLKCTL);
    assign clk_cmd.wr_div = wr_clk && (in_reg.word_offset == OFF_CLKDIV);

    pwmcd_clk #(
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_clk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (clk_cmd),
        .wdata   (in_reg.write_data),
        .stat    (clk_stat),
        .rd_ctl  (clk_rd_ctl),
        .rd_div  (clk_rd_div)
    );

    // channels
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic hit;

        // channel c owns word offsets 4c+4 to 4c+7
        assign hit = (in_reg.word_offset[5:2] == 4'(c + 1));

        assign chan_cmd[c].wr_range = wr_pwm && hit && (in_reg.word_offset[1:0] == SEL_RANGE);
        assign chan_cmd[c].wr_data  = wr_pwm && hit && (in_reg.word_offset[1:0] == SEL_DATA);
        assign chan_cmd[c].expire   = clk_stat.expire;
        assign chan_cmd[c].enable   = ctl_next[8 * c];

        pwmcd_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (chan_cmd[c]),
            .wdata      (in_reg.write_data),
            .rd_range   (chan_rd_range[c]),
            .rd_data    (chan_rd_data[c]),
            .level_next (chan_level[c])
        );

        always_comb begin
            chan_rd[c] = '0;
            if (hit) begin
                case (in_reg.word_offset[1:0])
                    SEL_RANGE: chan_rd[c] = chan_rd_range[c];
                    SEL_DATA:  chan_rd[c] = chan_rd_data[c];
                    default:   chan_rd[c] = '0;
                endcase
            end
        end
    end

    if (CHANNELS > 1) begin : g_lvl1
        assign level1 = chan_level[1];
    end else begin : g_no_lvl1
        assign level1 = 1'b0;
    end

    // register read mux
    always_comb begin
        rd_value = '0;
        if (in_reg.region == REGION_PWM) begin
            if (in_reg.word_offset == OFF_CTL) begin
                rd_value = 32'(ctl_reg);
            end else begin
                for (int c = 0; c < CHANNELS; c++) begin
                    rd_value = rd_value | chan_rd[c];
                end
            end
        end else begin
            case (in_reg.word_offset)
                OFF_CLKCTL: rd_value = clk_rd_ctl;
                OFF_CLKDIV: rd_value = clk_rd_div;
                default:    rd_value = '0;
            endcase
        end
    end

    // result register
    always_comb begin
        m_item_next.read_data   = is_read ? rd_value : 32'd0;
        m_item_next.pwm_level_0 = chan_level[0];
        m_item_next.pwm_level_1 = level1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // an enabled clock always reports busy
    a_enable_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        clk_stat.enable |-> clk_stat.busy)
        else $error("clock enabled without busy");

    // a prescaler expiry happens only on a tick with the clock enabled
    a_expire_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        clk_stat.expire |-> (is_tick && clk_stat.enable))
        else $error("prescaler expiry outside an enabled tick");

    // a held item in the input stage is not dropped
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage item lost");

    // only a read produces nonzero read data
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_read) |=> (m_item.read_data == 32'd0))
        else $error("read data nonzero for a non-read transfer");

endmodule

// ===== tb/tb_two_channel_pwm_with_clock_divider.sv =====
// testbench for the two-channel pwm with clock divider: directed table, random traffic, scoreboard
module tb_two_channel_pwm_with_clock_divider;
    import pwmcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH         = 2;
    localparam int RAND_ITEMS  = 1020;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_WAIT    = 14;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    pwmcd_in_t  s_item;
    logic       m_valid;
    logic       m_ready;
    pwmcd_out_t m_item;

    two_channel_pwm_with_clock_divider #(
        .CHANNELS     (NCH),
        .DIVIDER_BITS (12)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // one row of the directed table; known rows carry a hand-typed result
    typedef struct {
        pwmcd_in_t  item;
        bit         known;
        pwmcd_out_t result;
    } table_row_t;

    table_row_t directed_table[$];
    pwmcd_out_t pending_results[$];

    // shadow copy of the block's registers and counters
    logic [15:0] shadow_ctl;
    logic [31:0] shadow_range [NCH];
    logic [31:0] shadow_data  [NCH];
    logic [31:0] shadow_count [NCH];
    logic [4:0]  shadow_clk_ctl;
    logic [11:0] shadow_clk_div;
    logic [11:0] shadow_prescale;
    logic        shadow_busy;

    int errors;
    int cycle_count;
    int n_reads, n_writes, n_ticks, n_other, n_expiries, n_wraps;
    int n_high0, n_high1, n_results;
    int send_calm, recv_calm;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d results pending", $time,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // wait before a transfer: long calm stretches mixed with random gaps
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 80);
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic pwmcd_in_t mk_item(logic [1:0] op, logic rgn, logic [5:0] off,
                                          logic [31:0] wd);
        pwmcd_in_t it;
        it.operation   = op;
        it.region      = rgn;
        it.word_offset = off;
        it.write_data  = wd;
        return it;
    endfunction

    function automatic table_row_t mk_row(logic [1:0] op, logic rgn, logic [5:0] off,
                                          logic [31:0] wd, bit known, logic [31:0] rd);
        table_row_t row;
        row.item   = mk_item(op, rgn, off, wd);
        row.known  = known;
        row.result = {rd, 1'b0, 1'b0};
        return row;
    endfunction

    // predict the result of one accepted item and update the shadow state
    function automatic pwmcd_out_t predict_pwm_result(pwmcd_in_t it);
        pwmcd_out_t  r;
        logic [5:0]  off;
        logic [31:0] wd;
        logic [32:0] nxt;
        logic [12:0] pnext;
        logic [12:0] div;
        int          c;
        r   = '0;
        off = it.word_offset;
        wd  = it.write_data;
        c   = (int'(off) - 4) / 4;
        case (it.operation)
            OP_READ: begin
                if (it.region == REGION_PWM) begin
                    if (off == OFF_CTL) begin
                        r.read_data = {16'h0, shadow_ctl};
                    end else if (off >= 6'd4 && off < 6'd4 + 4 * NCH) begin
                        if (off[1:0] == SEL_RANGE) r.read_data = shadow_range[c];
                        else if (off[1:0] == SEL_DATA) r.read_data = shadow_data[c];
                    end
                end else begin
                    if (off == OFF_CLKCTL)
                        r.read_data = {24'h0, shadow_busy, 2'b00, shadow_clk_ctl};
                    else if (off == OFF_CLKDIV)
                        r.read_data = {8'h0, shadow_clk_div, 12'h0};
                end
            end
            OP_WRITE: begin
                if (it.region == REGION_PWM) begin
                    if (off == OFF_CTL) begin
                        shadow_ctl = wd[15:0];
                    end else if (off >= 6'd4 && off < 6'd4 + 4 * NCH) begin
                        if (off[1:0] == SEL_RANGE) shadow_range[c] = wd;
                        else if (off[1:0] == SEL_DATA) shadow_data[c] = wd;
                    end
                end else if (wd[31:24] == CLK_PASSWORD) begin
                    if (off == OFF_CLKCTL) begin
                        shadow_clk_ctl = wd[CLK_CTL_W-1:0];
                        if (shadow_clk_ctl[CLK_EN_BIT]) shadow_busy = 1'b1;
                    end else if (off == OFF_CLKDIV) begin
                        shadow_clk_div = wd[DIV_LSB +: 12];
                    end
                end
            end
            OP_TICK: begin
                if (!shadow_clk_ctl[CLK_EN_BIT]) begin
                    shadow_busy = 1'b0;
                end else begin
                    // a divider of zero behaves as one
                    div   = (shadow_clk_div == 12'd0) ? 13'd1 : {1'b0, shadow_clk_div};
                    pnext = {1'b0, shadow_prescale} + 13'd1;
                    if (pnext < div) begin
                        shadow_prescale = pnext[11:0];
                    end else begin
                        shadow_prescale = '0;
                        n_expiries++;
                        for (int k = 0; k < NCH; k++) begin
                            if (shadow_ctl[8*k]) begin
                                nxt = {1'b0, shadow_count[k]} + 33'd1;
                                if (nxt >= {1'b0, shadow_range[k]}) begin
                                    shadow_count[k] = '0;
                                    n_wraps++;
                                end else begin
                                    shadow_count[k] = nxt[31:0];
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.pwm_level_0 = shadow_ctl[0] && (shadow_count[0] < shadow_data[0]);
        r.pwm_level_1 = shadow_ctl[8] && (shadow_count[1] < shadow_data[1]);
        return r;
    endfunction

    // random item: mostly ticks and well-formed register traffic, some noise
    function automatic pwmcd_in_t rand_item();
        pwmcd_in_t   it;
        logic [31:0] wd;
        int          pick;
        int          sel;
        pick = $urandom_range(0, 99);
        wd   = $urandom;
        sel  = $urandom_range(0, 6);
        if (pick < 50) begin
            it = mk_item(OP_TICK, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), wd);
        end else if (pick < 62) begin
            // read a mapped register
            case (sel)
                0:       it = mk_item(OP_READ, REGION_PWM, OFF_CTL, wd);
                1:       it = mk_item(OP_READ, REGION_PWM, 6'd4, wd);
                2:       it = mk_item(OP_READ, REGION_PWM, 6'd5, wd);
                3:       it = mk_item(OP_READ, REGION_PWM, 6'd8, wd);
                4:       it = mk_item(OP_READ, REGION_PWM, 6'd9, wd);
                5:       it = mk_item(OP_READ, REGION_CLK, OFF_CLKCTL, wd);
                default: it = mk_item(OP_READ, REGION_CLK, OFF_CLKDIV, wd);
            endcase
        end else if (pick < 82) begin
            // channel register writes with small ranges so counters wrap often
            sel = $urandom_range(0, 4);
            if (sel == 0) begin
                wd[0] = ($urandom_range(0, 3) != 0);
                wd[8] = ($urandom_range(0, 3) != 0);
                it = mk_item(OP_WRITE, REGION_PWM, OFF_CTL, wd);
            end else begin
                if ($urandom_range(0, 9) != 0)
                    wd = (sel[0]) ? $urandom_range(0, 12) : $urandom_range(0, 14);
                it = mk_item(OP_WRITE, REGION_PWM, (sel > 2) ? 6'd8 : 6'd4, wd);
                it.word_offset[0] = ~sel[0];
            end
        end else if (pick < 90) begin
            // clock manager writes, mostly with the right password
            if ($urandom_range(0, 7) != 0) wd[31:24] = CLK_PASSWORD;
            if ($urandom_range(0, 1) == 0) begin
                wd[CLK_EN_BIT] = ($urandom_range(0, 4) != 0);
                it = mk_item(OP_WRITE, REGION_CLK, OFF_CLKCTL, wd);
            end else begin
                if ($urandom_range(0, 9) != 0) wd[DIV_LSB +: 12] = 12'($urandom_range(0, 3));
                it = mk_item(OP_WRITE, REGION_CLK, OFF_CLKDIV, wd);
            end
        end else begin
            it = mk_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         6'($urandom_range(0, 63)), wd);
        end
        return it;
    endfunction

    // drive one transfer, then record its expected result
    task automatic send_item(pwmcd_in_t it, bit known, pwmcd_out_t known_res);
        int         gap;
        pwmcd_out_t r;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        r = predict_pwm_result(it);
        if (known) r = known_res;
        pending_results.push_back(r);
        case (it.operation)
            OP_READ:  n_reads++;
            OP_WRITE: n_writes++;
            OP_TICK:  n_ticks++;
            default:  n_other++;
        endcase
    endtask

    // result side: random stalls before each transfer
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        pwmcd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_item.pwm_level_0) n_high0++;
            if (m_item.pwm_level_1) n_high1++;
            if (pending_results.size() == 0) begin
                $display("%0t: result %h with nothing expected", $time, m_item);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_item.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h got %h", $time,
                             want.read_data, m_item.read_data);
                    errors++;
                end
                if (m_item.pwm_level_0 !== want.pwm_level_0) begin
                    $display("%0t: pwm_level_0 expected %b got %b", $time,
                             want.pwm_level_0, m_item.pwm_level_0);
                    errors++;
                end
                if (m_item.pwm_level_1 !== want.pwm_level_1) begin
                    $display("%0t: pwm_level_1 expected %b got %b", $time,
                             want.pwm_level_1, m_item.pwm_level_1);
                    errors++;
                end
            end
        end
    end

    // reset, directed table, random traffic, drain
    initial begin
        errors     = 0;
        n_reads    = 0;
        n_writes   = 0;
        n_ticks    = 0;
        n_other    = 0;
        n_expiries = 0;
        n_wraps    = 0;
        n_high0    = 0;
        n_high1    = 0;
        n_results  = 0;
        send_calm  = 0;
        recv_calm  = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_item     = '0;

        // shadow state at reset
        shadow_ctl      = '0;
        shadow_clk_ctl  = '0;
        shadow_clk_div  = '0;
        shadow_prescale = '0;
        shadow_busy     = 1'b0;
        for (int k = 0; k < NCH; k++) begin
            shadow_range[k] = RANGE_RESET;
            shadow_data[k]  = '0;
            shadow_count[k] = '0;
        end

        // reset values and unmapped reads are typed in
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, OFF_CTL, 32'hFFFF_FFFF, 1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, 6'd4, 32'h0, 1, RANGE_RESET));
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, 6'd5, 32'h0, 1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, 6'd8, 32'h0, 1, RANGE_RESET));
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, 6'd9, 32'h0, 1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_CLK, OFF_CLKCTL, 32'h0, 1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_CLK, OFF_CLKDIV, 32'h0, 1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, 6'd63, 32'h0, 1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_PWM, 6'd2, 32'h0, 1, 32'd0));
        // wrong password leaves the clock off
        directed_table.push_back(mk_row(OP_WRITE, REGION_CLK, OFF_CLKCTL, 32'hA500_0011,
                                        1, 32'd0));
        directed_table.push_back(mk_row(OP_READ, REGION_CLK, OFF_CLKCTL, 32'h0, 1, 32'd0));
        // channel setup: both enabled with mark-space, zero range on channel 1
        directed_table.push_back(mk_row(OP_WRITE, REGION_PWM, OFF_CTL, 32'hFFFF_8181, 0, 0));
        directed_table.push_back(mk_row(OP_WRITE, REGION_PWM, 6'd4, 32'd3, 0, 0));
        directed_table.push_back(mk_row(OP_WRITE, REGION_PWM, 6'd5, 32'd2, 0, 0));
        directed_table.push_back(mk_row(OP_WRITE, REGION_PWM, 6'd8, 32'd0, 0, 0));
        directed_table.push_back(mk_row(OP_WRITE, REGION_PWM, 6'd9, 32'hFFFF_FFFF, 0, 0));
        // enable clock with divider zero: every tick expires
        directed_table.push_back(mk_row(OP_WRITE, REGION_CLK, OFF_CLKCTL, 32'h5A00_0011, 0, 0));
        directed_table.push_back(mk_row(OP_READ, REGION_CLK, OFF_CLKCTL, 32'h0, 0, 0));
        directed_table.push_back(mk_row(OP_TICK, REGION_PWM, 6'd0, 32'h0, 0, 0));
        directed_table.push_back(mk_row(OP_TICK, REGION_CLK, 6'd63, 32'hFFFF_FFFF, 0, 0));
        directed_table.push_back(mk_row(OP_TICK, REGION_PWM, 6'd0, 32'h0, 0, 0));
        // largest divider written while busy
        directed_table.push_back(mk_row(OP_WRITE, REGION_CLK, OFF_CLKDIV, 32'h5AFF_FFFF, 0, 0));
        directed_table.push_back(mk_row(OP_READ, REGION_CLK, OFF_CLKDIV, 32'h0, 0, 0));
        // disable, then the next tick clears busy
        directed_table.push_back(mk_row(OP_WRITE, REGION_CLK, OFF_CLKCTL, 32'h5A00_0000, 0, 0));
        directed_table.push_back(mk_row(OP_TICK, REGION_PWM, 6'd0, 32'h0, 0, 0));
        directed_table.push_back(mk_row(OP_READ, REGION_CLK, OFF_CLKCTL, 32'h0, 0, 0));
        // unused operation code
        directed_table.push_back(mk_row(2'd3, REGION_CLK, 6'd63, 32'hFFFF_FFFF, 0, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_table[i])
            send_item(directed_table[i].item, directed_table[i].known,
                      directed_table[i].result);

        // restore a short divider so random ticks move the counters
        send_item(mk_item(OP_WRITE, REGION_CLK, OFF_CLKDIV, 32'h5A00_1000), 0, '0);
        send_item(mk_item(OP_WRITE, REGION_CLK, OFF_CLKCTL, 32'h5A00_0013), 0, '0);

        for (int n = 0; n < RAND_ITEMS; n++)
            send_item(rand_item(), 0, '0);
        s_valid <= 1'b0;

        // drain, then keep watching for stray results
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d reads, %0d writes, %0d ticks, %0d unused ops; %0d results",
                 n_reads, n_writes, n_ticks, n_other, n_results);
        $display("prescaler expiries %0d, counter wraps %0d, high levels %0d / %0d",
                 n_expiries, n_wraps, n_high0, n_high1);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
